>>> rtl/rvu8v_pkg.sv
`default_nettype none
package rvu8v_pkg;

  localparam int unsigned NumClasses   = 15;
  localparam int unsigned Utf8Classes  = 12;
  localparam int unsigned FramedStates = 12;
  localparam int unsigned PlainStates  = 9;

  localparam logic [7:0] RowEndByte   = 8'hFD;
  localparam logic [7:0] NullByte     = 8'hFE;
  localparam logic [7:0] ValueEndByte = 8'hFF;

  typedef logic [3:0] cls_t;
  typedef logic [3:0] pstate_t;

  // byte classes
  localparam cls_t ClsInvalid  = 4'd0;
  localparam cls_t ClsAscii    = 4'd1;
  localparam cls_t ClsCont8x   = 4'd2;
  localparam cls_t ClsCont9x   = 4'd3;
  localparam cls_t ClsContAB   = 4'd4;
  localparam cls_t ClsLead2    = 4'd5;
  localparam cls_t ClsLeadE0   = 4'd6;
  localparam cls_t ClsLead3    = 4'd7;
  localparam cls_t ClsLeadED   = 4'd8;
  localparam cls_t ClsLeadF0   = 4'd9;
  localparam cls_t ClsLead4    = 4'd10;
  localparam cls_t ClsLeadF4   = 4'd11;
  localparam cls_t ClsRowEnd   = 4'd12;
  localparam cls_t ClsNull     = 4'd13;
  localparam cls_t ClsValueEnd = 4'd14;

  localparam pstate_t StError = 4'd0;
  localparam pstate_t StStart = 4'd1;

  localparam pstate_t FramedNext [FramedStates][NumClasses] = '{
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd0, 4'd0, 4'd0, 4'd3, 4'd4, 4'd6, 4'd5, 4'd7, 4'd8, 4'd9, 4'd1, 4'd10, 4'd11},
    '{4'd0, 4'd2, 4'd0, 4'd0, 4'd0, 4'd3, 4'd4, 4'd6, 4'd5, 4'd7, 4'd8, 4'd9, 4'd0, 4'd0, 4'd11},
    '{4'd0, 4'd0, 4'd2, 4'd2, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd0, 4'd3, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd0, 4'd3, 4'd3, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd6, 4'd6, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd0, 4'd6, 4'd6, 4'd6, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd0, 4'd6, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd11},
    '{4'd0, 4'd2, 4'd0, 4'd0, 4'd0, 4'd3, 4'd4, 4'd6, 4'd5, 4'd7, 4'd8, 4'd9, 4'd1, 4'd10, 4'd11}
  };

  localparam pstate_t PlainNext [PlainStates][Utf8Classes] = '{
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd1, 4'd0, 4'd0, 4'd0, 4'd2, 4'd3, 4'd5, 4'd4, 4'd6, 4'd7, 4'd8},
    '{4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd0, 4'd2, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd0, 4'd2, 4'd2, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd5, 4'd5, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd0, 4'd5, 4'd5, 4'd5, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd0, 4'd5, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       carries_byte;
    logic       last_item;
  } item_t;

  typedef struct packed {
    logic still_valid;
    logic row_closed;
    logic document_end;
    logic document_valid;
  } result_t;

  function automatic cls_t classify(input logic [7:0] b);
    cls_t c;
    priority if (b < 8'h80)      c = ClsAscii;
    else if (b < 8'h90)          c = ClsCont8x;
    else if (b < 8'hA0)          c = ClsCont9x;
    else if (b < 8'hC0)          c = ClsContAB;
    else if (b < 8'hC2)          c = ClsInvalid;
    else if (b < 8'hE0)          c = ClsLead2;
    else if (b == 8'hE0)         c = ClsLeadE0;
    else if (b == 8'hED)         c = ClsLeadED;
    else if (b < 8'hF0)          c = ClsLead3;
    else if (b == 8'hF0)         c = ClsLeadF0;
    else if (b < 8'hF4)          c = ClsLead4;
    else if (b == 8'hF4)         c = ClsLeadF4;
    else if (b == RowEndByte)    c = ClsRowEnd;
    else if (b == NullByte)      c = ClsNull;
    else if (b == ValueEndByte)  c = ClsValueEnd;
    else                         c = ClsInvalid;
    return c;
  endfunction

  function automatic pstate_t advance(input logic plain, input pstate_t st, input cls_t c);
    pstate_t n;
    cls_t    pc;
    pc = (c >= cls_t'(Utf8Classes)) ? ClsInvalid : c;
    n  = StError;
    if (plain) begin
      if (st < pstate_t'(PlainStates)) begin
        n = PlainNext[st][pc];
      end
    end else begin
      if (st < pstate_t'(FramedStates) && c < cls_t'(NumClasses)) begin
        n = FramedNext[st][c];
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

>>> rtl/rvu8v_in_stage.sv
`default_nettype none
module rvu8v_in_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire rvu8v_pkg::item_t item_i,
  input  wire logic            advance_i,
  output logic                 valid_o,
  output rvu8v_pkg::item_t     item_o
);
  import rvu8v_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = !in_stall_o;
  assign valid_d    = load ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule
`default_nettype wire

>>> rtl/rvu8v_step.sv
`default_nettype none
module rvu8v_step (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_wdata_i,
  input  wire rvu8v_pkg::item_t item_i,
  input  wire logic             fire_i,
  output rvu8v_pkg::result_t    result_o
);
  import rvu8v_pkg::*;

  logic    mode_q, mode_d;
  pstate_t state_q, state_d;
  pstate_t st_n;
  cls_t    cls;

  always_comb begin
    cls  = classify(item_i.data_byte);
    st_n = item_i.carries_byte ? advance(mode_q, state_q, cls) : state_q;

    result_o.still_valid    = (st_n != StError);
    result_o.row_closed     = item_i.carries_byte && !mode_q && (cls == ClsRowEnd)
                              && (st_n == StStart);
    result_o.document_end   = item_i.last_item;
    result_o.document_valid = item_i.last_item && (st_n == StStart);
  end

  // a mode write restarts the current document
  always_comb begin
    mode_d  = mode_q;
    state_d = state_q;
    if (cfg_we_i) begin
      mode_d  = cfg_wdata_i;
      state_d = StStart;
    end else if (fire_i) begin
      state_d = item_i.last_item ? StStart : st_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      state_q <= StStart;
    end else begin
      mode_q  <= mode_d;
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

>>> rtl/row_value_utf8_validator_unit.sv
`default_nettype none
// Streaming validator for strict UTF-8 and for row/value framed documents
// (0xFD row end, 0xFE null, 0xFF value end), one byte per transaction and one
// result per transaction. A transaction is registered at the input, classified
// and stepped through the automaton, and its result is registered at the
// output. One transaction can be taken every cycle while the output is not
// stalled by out_stall_i; a stalled output holds the input stage.
// A mode write with cfg_wdata_i high selects plain UTF-8 checking (FD/FE/FF
// invalid); every mode write restarts the current document, so write it only
// while no transaction is in flight.
module row_value_utf8_validator_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       carries_byte_i,
  input  wire logic       last_item_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            still_valid_o,
  output logic            row_closed_o,
  output logic            document_end_o,
  output logic            document_valid_o
);
  import rvu8v_pkg::*;

  item_t   in_item, s1_item;
  logic    s1_valid;
  logic    out_free;
  logic    fire;
  result_t res;
  result_t res_q;
  logic    out_valid_q, out_valid_d;

  assign in_item.data_byte    = data_byte_i;
  assign in_item.carries_byte = carries_byte_i;
  assign in_item.last_item    = last_item_i;

  assign out_free = !out_valid_q || !out_stall_i;
  assign fire     = s1_valid && out_free;

  rvu8v_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (out_free),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  rvu8v_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (s1_item),
    .fire_i      (fire),
    .result_o    (res)
  );

  assign out_valid_d = out_free ? s1_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign still_valid_o    = res_q.still_valid;
  assign row_closed_o     = res_q.row_closed;
  assign document_end_o   = res_q.document_end;
  assign document_valid_o = res_q.document_valid;
endmodule
`default_nettype wire
